// ===== hdl/ffha_pkg.sv =====
`default_nettype none
package ffha_pkg;

   localparam int OFFSET_W = 16;
   localparam int SIZE_W   = 16;
   localparam int LIMIT_W  = 17;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic [1:0] STATUS_DONE         = 2'd0;
   localparam logic [1:0] STATUS_ALLOC_FAIL   = 2'd1;
   localparam logic [1:0] STATUS_FREE_IGNORED = 2'd2;

   localparam logic [CSR_ADDR_W-1:0] CSR_HEAP_LIMIT = 3'd0;
   localparam logic [LIMIT_W-1:0]    LIMIT_RESET    = 17'h10000;

   typedef struct packed {
      logic pop;
      logic push;
   } slot_cmd_type;

endpackage
`default_nettype wire

// ===== hdl/ffha_if.sv =====
`default_nettype none
interface ffha_req_if import ffha_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                operation;
   logic [SIZE_W-1:0]   request_size;
   logic [OFFSET_W-1:0] release_offset;

   modport source (output valid, operation, request_size, release_offset, input ready);
   modport sink   (input valid, operation, request_size, release_offset, output ready);
endinterface

interface ffha_rsp_if import ffha_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [OFFSET_W-1:0] granted_offset;
   logic [1:0]          status;

   modport source (output valid, granted_offset, status, input ready);
   modport sink   (input valid, granted_offset, status, output ready);
endinterface
`default_nettype wire

// ===== hdl/ffha_ram.sv =====
`default_nettype none
module ffha_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== hdl/ffha_slot_pool.sv =====
`default_nettype none
// Slot allocator: never-used slots come from a fill counter, recycled ones
// from a stack in RAM. A popped slot number is valid the cycle after pop.
module ffha_slot_pool import ffha_pkg::*; #(
   parameter int DEPTH = 1024,
   localparam int IW = $clog2(DEPTH),
   localparam int CW = $clog2(DEPTH + 1)
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire slot_cmd_type  cmd,
   input  wire logic [IW-1:0] push_idx,
   output logic               avail,
   output logic [IW-1:0]      slot_idx
);

   logic [CW-1:0] sp_ff, sp_in;
   logic [CW-1:0] fresh_ff, fresh_in;
   logic [IW-1:0] fresh_slot_ff, fresh_slot_in;
   logic          from_stack_ff, from_stack_in;
   logic [IW-1:0] stk_raddr;
   logic [IW-1:0] stk_q;

   assign avail = (sp_ff != '0) || (fresh_ff != CW'(DEPTH));

   always_comb begin
      sp_in         = sp_ff;
      fresh_in      = fresh_ff;
      fresh_slot_in = fresh_slot_ff;
      from_stack_in = from_stack_ff;
      stk_raddr     = IW'(sp_ff - 1'b1);
      if (cmd.pop) begin
         if (sp_ff != '0) begin
            sp_in         = sp_ff - 1'b1;
            from_stack_in = 1'b1;
         end else begin
            fresh_slot_in = fresh_ff[IW-1:0];
            fresh_in      = fresh_ff + 1'b1;
            from_stack_in = 1'b0;
         end
      end else if (cmd.push) begin
         sp_in = sp_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff         <= '0;
         fresh_ff      <= '0;
         from_stack_ff <= 1'b0;
      end else begin
         sp_ff         <= sp_in;
         fresh_ff      <= fresh_in;
         from_stack_ff <= from_stack_in;
      end
      fresh_slot_ff <= fresh_slot_in;
   end

   ffha_ram #(.WIDTH(IW), .DEPTH(DEPTH)) u_stack (
      .clock   (clock),
      .wr_en   (cmd.push),
      .wr_addr (sp_ff[IW-1:0]),
      .wr_data (push_idx),
      .rd_addr (stk_raddr),
      .rd_data (stk_q)
   );

   assign slot_idx = from_stack_ff ? stk_q : fresh_slot_ff;

endmodule
`default_nettype wire

// ===== hdl/ffha_ctrl.sv =====
`default_nettype none
module ffha_ctrl import ffha_pkg::*; #(
   parameter int MAX_BLOCKS   = 1024,
   parameter int HEADER_BYTES = 32,
   parameter int WORD_BYTES   = 8,
   localparam int IW = $clog2(MAX_BLOCKS)
) (
   input  wire logic               clock,
   input  wire logic               reset,
   ffha_req_if.sink                req,
   ffha_rsp_if.source              rsp,
   input  wire logic [LIMIT_W-1:0] limit,
   output slot_cmd_type            slot_cmd,
   output logic [IW-1:0]           push_idx,
   input  wire logic               slot_avail,
   input  wire logic [IW-1:0]      slot_idx
);

   typedef struct packed {
      logic [OFFSET_W-1:0] start;
      logic [SIZE_W-1:0]   size;
      logic                is_free;
      logic                has_next;
      logic [IW-1:0]       nxt;
      logic                has_prev;
      logic [IW-1:0]       prv;
   } entry_type;

   localparam int EW = $bits(entry_type);
   localparam logic [17:0] H18 = 18'(HEADER_BYTES);
   localparam logic [15:0] H16 = 16'(HEADER_BYTES);
   localparam logic [4:0]  W5  = 5'(WORD_BYTES);
   // reciprocal of the word size, exact for any 17-bit dividend
   localparam int          RK  = 22;
   localparam logic [22:0] RM  = 23'(((1 << RK) + WORD_BYTES - 1) / WORD_BYTES);

   typedef enum logic [16:0] {
      ST_IDLE        = 17'h00001,
      ST_ROUND       = 17'h00002,
      ST_ALLOC_GO    = 17'h00004,
      ST_WALK_RD     = 17'h00008,
      ST_WALK_CHK    = 17'h00010,
      ST_SPLIT_WAIT  = 17'h00020,
      ST_SPLIT_WE    = 17'h00040,
      ST_APPEND_CHK  = 17'h00080,
      ST_APPEND_WR   = 17'h00100,
      ST_APPEND_LINK = 17'h00200,
      ST_PREV_RD     = 17'h00400,
      ST_PREV_CHK    = 17'h00800,
      ST_NEXT_DECIDE = 17'h01000,
      ST_NEXT_CHK    = 17'h02000,
      ST_FIX_RD      = 17'h04000,
      ST_FIX_WR      = 17'h08000,
      ST_DONE        = 17'h10000
   } state_type;

   state_type state_ff, state_in, fix_ret_ff, fix_ret_in;

   logic                lv_ff, lv_in;
   logic [IW-1:0]       first_ff, first_in;
   logic [LIMIT_W-1:0]  top_ff, top_in;
   logic                op_ff, op_in;
   logic [SIZE_W-1:0]   req_ff, req_in;
   logic [16:0]         quo_ff, quo_in;
   logic [16:0]         sz_ff, sz_in;
   logic [OFFSET_W-1:0] off_ff, off_in;
   logic [IW-1:0]       cur_ff, cur_in;
   logic [IW-1:0]       wi_ff, wi_in;
   logic [IW-1:0]       n_ff, n_in;
   entry_type           w_ff, w_in;
   logic [IW-1:0]       fix_idx_ff, fix_idx_in;
   logic [IW-1:0]       fix_val_ff, fix_val_in;
   logic                fix_clr_ff, fix_clr_in;
   logic [OFFSET_W-1:0] res_off_ff, res_off_in;
   logic [1:0]          res_st_ff, res_st_in;
   logic                rsp_v_ff, rsp_v_in;
   logic [OFFSET_W-1:0] rsp_off_ff, rsp_off_in;
   logic [1:0]          rsp_st_ff, rsp_st_in;

   logic          ram_we;
   logic [IW-1:0] ram_waddr, ram_raddr;
   logic [EW-1:0] ram_wdata, ram_rdata;

   // true when block b starts right after block a
   function automatic logic contig(input entry_type a, input entry_type b);
      return ({2'b0, a.start} + {2'b0, a.size} + H18) == {2'b0, b.start};
   endfunction

   assign req.ready         = (state_ff == ST_IDLE);
   assign rsp.valid          = rsp_v_ff;
   assign rsp.granted_offset = rsp_off_ff;
   assign rsp.status         = rsp_st_ff;

   always_comb begin : seq_comb
      entry_type   q;
      entry_type   t;
      logic [16:0] biased;
      logic [39:0] prod;
      logic [17:0] need;
      logic [16:0] span;
      q          = entry_type'(ram_rdata);
      t          = w_ff;
      biased     = {1'b0, req_ff} + 17'(WORD_BYTES - 1);
      prod       = {23'b0, biased} * {17'b0, RM};
      need       = {1'b0, top_ff} + {1'b0, sz_ff} + H18;
      span       = {1'b0, w_ff.size} + {1'b0, H16};
      state_in   = state_ff;
      fix_ret_in = fix_ret_ff;
      lv_in      = lv_ff;
      first_in   = first_ff;
      top_in     = top_ff;
      op_in      = op_ff;
      req_in     = req_ff;
      quo_in     = quo_ff;
      sz_in      = sz_ff;
      off_in     = off_ff;
      cur_in     = cur_ff;
      wi_in      = wi_ff;
      n_in       = n_ff;
      w_in       = w_ff;
      fix_idx_in = fix_idx_ff;
      fix_val_in = fix_val_ff;
      fix_clr_in = fix_clr_ff;
      res_off_in = res_off_ff;
      res_st_in  = res_st_ff;
      rsp_v_in   = rsp_v_ff;
      rsp_off_in = rsp_off_ff;
      rsp_st_in  = rsp_st_ff;
      ram_we     = 1'b0;
      ram_waddr  = wi_ff;
      ram_wdata  = w_ff;
      ram_raddr  = cur_ff;
      slot_cmd   = '0;
      push_idx   = wi_ff;

      if (rsp_v_ff && rsp.ready) begin
         rsp_v_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               op_in      = req.operation;
               res_off_in = '0;
               res_st_in  = STATUS_DONE;
               if (req.operation == OP_ALLOC) begin
                  if (req.request_size == '0) begin
                     res_st_in = STATUS_ALLOC_FAIL;
                     state_in  = ST_DONE;
                  end else begin
                     req_in    = req.request_size;
                     state_in  = ST_ROUND;
                  end
               end else begin
                  off_in = req.release_offset;
                  if (req.release_offset == '0 || !lv_ff ||
                      {1'b0, req.release_offset} >= top_ff) begin
                     res_st_in = STATUS_FREE_IGNORED;
                     state_in  = ST_DONE;
                  end else begin
                     cur_in   = first_ff;
                     state_in = ST_WALK_RD;
                  end
               end
            end
         end
         // word count of the rounded-up size
         ST_ROUND: begin
            quo_in   = prod[RK +: 17];
            state_in = ST_ALLOC_GO;
         end
         ST_ALLOC_GO: begin
            sz_in = quo_ff * {12'b0, W5};
            if (lv_ff) begin
               cur_in   = first_ff;
               state_in = ST_WALK_RD;
            end else begin
               state_in = ST_APPEND_CHK;
            end
         end
         ST_WALK_RD: begin
            ram_raddr = cur_ff;
            state_in  = ST_WALK_CHK;
         end
         ST_WALK_CHK: begin
            w_in  = q;
            wi_in = cur_ff;
            if (op_ff == OP_ALLOC) begin
               if (q.is_free && ({1'b0, q.size} >= sz_ff)) begin
                  if (({2'b0, q.size} > ({1'b0, sz_ff} + H18)) && slot_avail) begin
                     slot_cmd.pop = 1'b1;
                     state_in     = ST_SPLIT_WAIT;
                  end else begin
                     t          = q;
                     t.is_free  = 1'b0;
                     ram_we     = 1'b1;
                     ram_waddr  = cur_ff;
                     ram_wdata  = t;
                     res_off_in = q.start;
                     state_in   = ST_DONE;
                  end
               end else if (q.has_next) begin
                  cur_in   = q.nxt;
                  state_in = ST_WALK_RD;
               end else begin
                  state_in = ST_APPEND_CHK;
               end
            end else begin
               if (q.start == off_ff) begin
                  if (q.is_free) begin
                     res_st_in = STATUS_FREE_IGNORED;
                     state_in  = ST_DONE;
                  end else begin
                     w_in.is_free = 1'b1;
                     state_in     = q.has_prev ? ST_PREV_RD : ST_NEXT_DECIDE;
                  end
               end else if (q.has_next) begin
                  cur_in   = q.nxt;
                  state_in = ST_WALK_RD;
               end else begin
                  res_st_in = STATUS_FREE_IGNORED;
                  state_in  = ST_DONE;
               end
            end
         end
         ST_SPLIT_WAIT: begin
            n_in       = slot_idx;
            t.start    = w_ff.start + sz_ff[15:0] + H16;
            t.size     = w_ff.size - sz_ff[15:0] - H16;
            t.is_free  = 1'b1;
            t.has_next = w_ff.has_next;
            t.nxt      = w_ff.nxt;
            t.has_prev = 1'b1;
            t.prv      = wi_ff;
            ram_we     = 1'b1;
            ram_waddr  = slot_idx;
            ram_wdata  = t;
            state_in   = ST_SPLIT_WE;
         end
         ST_SPLIT_WE: begin
            t.size     = sz_ff[15:0];
            t.has_next = 1'b1;
            t.nxt      = n_ff;
            t.is_free  = 1'b0;
            ram_we     = 1'b1;
            ram_waddr  = wi_ff;
            ram_wdata  = t;
            res_off_in = w_ff.start;
            if (w_ff.has_next) begin
               fix_idx_in = w_ff.nxt;
               fix_val_in = n_ff;
               fix_clr_in = 1'b0;
               fix_ret_in = ST_DONE;
               state_in   = ST_FIX_RD;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_APPEND_CHK: begin
            if (need > {1'b0, limit} || !slot_avail) begin
               res_st_in = STATUS_ALLOC_FAIL;
               state_in  = ST_DONE;
            end else begin
               slot_cmd.pop = 1'b1;
               state_in     = ST_APPEND_WR;
            end
         end
         ST_APPEND_WR: begin
            n_in       = slot_idx;
            t.start    = top_ff[15:0] + H16;
            t.size     = sz_ff[15:0];
            t.is_free  = 1'b0;
            t.has_next = 1'b0;
            t.nxt      = '0;
            t.has_prev = lv_ff;
            t.prv      = wi_ff;
            ram_we     = 1'b1;
            ram_waddr  = slot_idx;
            ram_wdata  = t;
            res_off_in = t.start;
            top_in     = need[16:0];
            if (lv_ff) begin
               state_in = ST_APPEND_LINK;
            end else begin
               first_in = slot_idx;
               lv_in    = 1'b1;
               state_in = ST_DONE;
            end
         end
         ST_APPEND_LINK: begin
            t.has_next = 1'b1;
            t.nxt      = n_ff;
            ram_we     = 1'b1;
            ram_waddr  = wi_ff;
            ram_wdata  = t;
            state_in   = ST_DONE;
         end
         ST_PREV_RD: begin
            ram_raddr = w_ff.prv;
            state_in  = ST_PREV_CHK;
         end
         ST_PREV_CHK: begin
            state_in = ST_NEXT_DECIDE;
            if (q.is_free) begin
               wi_in = w_ff.prv;
               if (contig(q, w_ff)) begin
                  t          = q;
                  t.size     = q.size + H16 + w_ff.size;
                  t.has_next = w_ff.has_next;
                  t.nxt      = w_ff.nxt;
                  w_in       = t;
                  slot_cmd.push = 1'b1;
                  push_idx   = wi_ff;
                  if (w_ff.has_next) begin
                     fix_idx_in = w_ff.nxt;
                     fix_val_in = w_ff.prv;
                     fix_clr_in = 1'b0;
                     fix_ret_in = ST_NEXT_DECIDE;
                     state_in   = ST_FIX_RD;
                  end
               end else begin
                  ram_we    = 1'b1;
                  ram_waddr = wi_ff;
                  ram_wdata = w_ff;
                  w_in      = q;
               end
            end
         end
         ST_NEXT_DECIDE: begin
            res_off_in = '0;
            res_st_in  = STATUS_DONE;
            if (w_ff.has_next) begin
               ram_raddr = w_ff.nxt;
               state_in  = ST_NEXT_CHK;
            end else begin
               // last block leaves the heap
               slot_cmd.push = 1'b1;
               push_idx      = wi_ff;
               top_in        = (span > top_ff) ? '0 : top_ff - span;
               if (w_ff.has_prev) begin
                  fix_idx_in = w_ff.prv;
                  fix_clr_in = 1'b1;
                  fix_ret_in = ST_DONE;
                  state_in   = ST_FIX_RD;
               end else begin
                  lv_in    = 1'b0;
                  state_in = ST_DONE;
               end
            end
         end
         ST_NEXT_CHK: begin
            ram_we    = 1'b1;
            ram_waddr = wi_ff;
            state_in  = ST_DONE;
            if (q.is_free && contig(w_ff, q)) begin
               t.size        = w_ff.size + H16 + q.size;
               t.has_next    = q.has_next;
               t.nxt         = q.nxt;
               slot_cmd.push = 1'b1;
               push_idx      = w_ff.nxt;
               if (q.has_next) begin
                  fix_idx_in = q.nxt;
                  fix_val_in = wi_ff;
                  fix_clr_in = 1'b0;
                  fix_ret_in = ST_DONE;
                  state_in   = ST_FIX_RD;
               end
            end
            ram_wdata = t;
         end
         ST_FIX_RD: begin
            ram_raddr = fix_idx_ff;
            state_in  = ST_FIX_WR;
         end
         ST_FIX_WR: begin
            t = q;
            if (fix_clr_ff) begin
               t.has_next = 1'b0;
            end else begin
               t.has_prev = 1'b1;
               t.prv      = fix_val_ff;
            end
            ram_we    = 1'b1;
            ram_waddr = fix_idx_ff;
            ram_wdata = t;
            state_in  = fix_ret_ff;
         end
         ST_DONE: begin
            if (!rsp_v_ff || rsp.ready) begin
               rsp_v_in   = 1'b1;
               rsp_off_in = res_off_ff;
               rsp_st_in  = res_st_ff;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         fix_ret_ff <= ST_DONE;
         lv_ff      <= 1'b0;
         top_ff     <= '0;
         rsp_v_ff   <= 1'b0;
      end else begin
         state_ff   <= state_in;
         fix_ret_ff <= fix_ret_in;
         lv_ff      <= lv_in;
         top_ff     <= top_in;
         rsp_v_ff   <= rsp_v_in;
      end
      first_ff   <= first_in;
      op_ff      <= op_in;
      req_ff     <= req_in;
      quo_ff     <= quo_in;
      sz_ff      <= sz_in;
      off_ff     <= off_in;
      cur_ff     <= cur_in;
      wi_ff      <= wi_in;
      n_ff       <= n_in;
      w_ff       <= w_in;
      fix_idx_ff <= fix_idx_in;
      fix_val_ff <= fix_val_in;
      fix_clr_ff <= fix_clr_in;
      res_off_ff <= res_off_in;
      res_st_ff  <= res_st_in;
      rsp_off_ff <= rsp_off_in;
      rsp_st_ff  <= rsp_st_in;
   end

   ffha_ram #(.WIDTH(EW), .DEPTH(MAX_BLOCKS)) u_block_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

endmodule
`default_nettype wire

// ===== hdl/first_fit_heap_allocator_unit.sv =====
`default_nettype none
// First-fit heap allocator with coalescing. Blocks sit in an address-ordered
// linked list held in a block table RAM with one read and one write port;
// every list step is a RAM read followed by a check. Allocate: accept the
// request, round the size, walk the blocks, then take, split or append a
// block. Free: accept the request, walk the blocks up to and including the
// target, then merge with neighbors or trim the heap top. Zero-size
// allocates and free offsets rejected on sight go from accept straight to
// the response. One word is worked on at a time; a new request word is
// taken while a finished response still waits, and the next response holds
// until that one is taken. No clearing pass after reset: unused slots are
// handed out from a fill counter.
module first_fit_heap_allocator_unit import ffha_pkg::*; #(
   parameter int HEAP_BYTES   = 65536,
   parameter int MAX_BLOCKS   = 1024,
   parameter int HEADER_BYTES = 32,
   parameter int WORD_BYTES   = 8
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   ffha_req_if.sink                   req_bus,
   ffha_rsp_if.source                 rsp_bus,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready
);

   localparam int IW = $clog2(MAX_BLOCKS);
   localparam logic [LIMIT_W-1:0] LIMIT_CAP =
      (HEAP_BYTES < 65536) ? LIMIT_W'(HEAP_BYTES) : LIMIT_RESET;

   logic [LIMIT_W-1:0] heap_limit_ff, heap_limit_in;
   logic [LIMIT_W-1:0] limit_eff;
   slot_cmd_type       slot_cmd;
   logic [IW-1:0]      push_idx;
   logic               slot_avail;
   logic [IW-1:0]      slot_idx;

   assign csr_pready = 1'b1;
   assign csr_prdata = CSR_DATA_W'(heap_limit_ff);

   // register select ignores the byte lane bits
   always_comb begin
      heap_limit_in = heap_limit_ff;
      if (csr_psel && csr_penable && csr_pwrite &&
          csr_paddr[CSR_ADDR_W-1:2] == CSR_HEAP_LIMIT[CSR_ADDR_W-1:2]) begin
         heap_limit_in = csr_pwdata[LIMIT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         heap_limit_ff <= LIMIT_RESET;
      end else begin
         heap_limit_ff <= heap_limit_in;
      end
   end

   assign limit_eff = (heap_limit_ff > LIMIT_CAP) ? LIMIT_CAP : heap_limit_ff;

   ffha_ctrl #(
      .MAX_BLOCKS   (MAX_BLOCKS),
      .HEADER_BYTES (HEADER_BYTES),
      .WORD_BYTES   (WORD_BYTES)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req        (req_bus),
      .rsp        (rsp_bus),
      .limit      (limit_eff),
      .slot_cmd   (slot_cmd),
      .push_idx   (push_idx),
      .slot_avail (slot_avail),
      .slot_idx   (slot_idx)
   );

   ffha_slot_pool #(.DEPTH(MAX_BLOCKS)) u_slot_pool (
      .clock    (clock),
      .reset    (reset),
      .cmd      (slot_cmd),
      .push_idx (push_idx),
      .avail    (slot_avail),
      .slot_idx (slot_idx)
   );

endmodule
`default_nettype wire

// ===== tb/first_fit_heap_allocator_unit_test.sv =====
module first_fit_heap_allocator_unit_test;
   import ffha_pkg::*;

   localparam int HDR   = 32;
   localparam int WB    = 8;
   localparam int SLOTS = 1024;
   localparam int HEAP  = 65536;
   localparam int CYCLE_LIMIT = 10000000;

   typedef struct {
      logic                op;
      logic [SIZE_W-1:0]   size;
      logic [OFFSET_W-1:0] off;
   } heap_req_type;

   typedef struct {
      logic [OFFSET_W-1:0] granted;
      logic [1:0]          status;
   } heap_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   ffha_req_if req_bus ();
   ffha_rsp_if rsp_bus ();

   first_fit_heap_allocator_unit uut (
      .clock(clock), .reset(reset), .req_bus(req_bus.sink), .rsp_bus(rsp_bus.source),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // heap shadow
   int unsigned blk_start [SLOTS];
   int unsigned blk_size  [SLOTS];
   bit          blk_free  [SLOTS];
   bit          blk_hnext [SLOTS];
   bit          blk_hprev [SLOTS];
   int unsigned blk_next  [SLOTS];
   int unsigned blk_prev  [SLOTS];
   bit          slot_unused [SLOTS];
   bit          list_live;
   int unsigned head_slot;
   int unsigned top_bytes;
   int unsigned limit_bytes;

   heap_req_type pending_reqs [$];
   heap_rsp_type awaited_rsps [$];
   int unsigned live_offsets [$];
   int unsigned freed_offsets [$];
   int err_count = 0;
   int cycles = 0;
   bit req_taken = 1'b0;
   int req_gap = 0;
   int rsp_hold = 0;
   bit long_hold = 1'b0;

   function automatic bit grab_slot(output int unsigned idx);
      for (int i = 0; i < SLOTS; i++) begin
         if (slot_unused[i]) begin
            slot_unused[i] = 1'b0;
            idx = i;
            return 1'b1;
         end
      end
      idx = 0;
      return 1'b0;
   endfunction

   function automatic void merge_with_next(int unsigned b);
      int unsigned ni;
      if (!blk_hnext[b]) return;
      ni = blk_next[b];
      if (!blk_free[ni] || blk_start[ni] - HDR != blk_start[b] + blk_size[b]) return;
      blk_size[b] += HDR + blk_size[ni];
      blk_hnext[b] = blk_hnext[ni];
      blk_next[b] = blk_next[ni];
      if (blk_hnext[b]) begin
         blk_prev[blk_next[b]] = b;
         blk_hprev[blk_next[b]] = 1'b1;
      end
      slot_unused[ni] = 1'b1;
   endfunction

   function automatic heap_rsp_type alloc_block(int unsigned req);
      heap_rsp_type r;
      int unsigned sz, cur, last, n, lim, need;
      bit have;
      r.granted = '0;
      r.status = STATUS_ALLOC_FAIL;
      if (req == 0) return r;
      sz = (req + WB - 1) / WB * WB;
      cur = head_slot;
      last = 0;
      have = list_live;
      while (have) begin
         if (blk_free[cur] && blk_size[cur] >= sz) begin
            if (blk_size[cur] > sz + HDR && grab_slot(n)) begin
               blk_start[n] = blk_start[cur] + sz + HDR;
               blk_size[n] = blk_size[cur] - (sz + HDR);
               blk_free[n] = 1'b1;
               blk_hnext[n] = blk_hnext[cur];
               blk_next[n] = blk_next[cur];
               blk_hprev[n] = 1'b1;
               blk_prev[n] = cur;
               if (blk_hnext[n]) begin
                  blk_prev[blk_next[n]] = n;
                  blk_hprev[blk_next[n]] = 1'b1;
               end
               blk_size[cur] = sz;
               blk_hnext[cur] = 1'b1;
               blk_next[cur] = n;
            end
            blk_free[cur] = 1'b0;
            r.status = STATUS_DONE;
            r.granted = blk_start[cur][15:0];
            return r;
         end
         last = cur;
         have = blk_hnext[cur];
         cur = blk_next[cur];
      end
      lim = limit_bytes;
      if (lim > HEAP) lim = HEAP;
      need = top_bytes + sz + HDR;
      if (need > lim || !grab_slot(n)) return r;
      blk_start[n] = top_bytes + HDR;
      blk_size[n] = sz;
      blk_free[n] = 1'b0;
      blk_hnext[n] = 1'b0;
      blk_next[n] = 0;
      blk_hprev[n] = list_live;
      blk_prev[n] = last;
      if (list_live) begin
         blk_hnext[last] = 1'b1;
         blk_next[last] = n;
      end else begin
         head_slot = n;
         list_live = 1'b1;
      end
      top_bytes = need;
      r.status = STATUS_DONE;
      r.granted = blk_start[n][15:0];
      return r;
   endfunction

   function automatic logic [1:0] release_block(int unsigned off);
      int unsigned cur, b, span;
      bit have;
      if (off == 0 || !list_live) return STATUS_FREE_IGNORED;
      if (off < blk_start[head_slot] - HDR || off >= top_bytes) return STATUS_FREE_IGNORED;
      cur = head_slot;
      have = 1'b1;
      while (have && blk_start[cur] != off) begin
         have = blk_hnext[cur];
         cur = blk_next[cur];
      end
      if (!have || blk_free[cur]) return STATUS_FREE_IGNORED;
      blk_free[cur] = 1'b1;
      b = cur;
      if (blk_hprev[b] && blk_free[blk_prev[b]]) begin
         b = blk_prev[b];
         merge_with_next(b);
      end
      if (blk_hnext[b]) begin
         merge_with_next(b);
      end else begin
         if (blk_hprev[b]) blk_hnext[blk_prev[b]] = 1'b0;
         else list_live = 1'b0;
         span = blk_size[b] + HDR;
         top_bytes = (span > top_bytes) ? 0 : top_bytes - span;
         slot_unused[b] = 1'b1;
      end
      return STATUS_DONE;
   endfunction

   task automatic queue_op(logic op, int unsigned size, int unsigned off);
      heap_req_type q;
      heap_rsp_type r;
      int idx;
      q.op = op;
      q.size = size[15:0];
      q.off = off[15:0];
      if (op == OP_ALLOC) begin
         r = alloc_block(q.size);
         if (r.status == STATUS_DONE) live_offsets.push_back(r.granted);
      end else begin
         r.granted = '0;
         r.status = release_block(q.off);
         if (r.status == STATUS_DONE) begin
            idx = -1;
            foreach (live_offsets[i]) if (live_offsets[i] == q.off) idx = i;
            if (idx >= 0) live_offsets.delete(idx);
            freed_offsets.push_back(q.off);
            if (freed_offsets.size() > 16) void'(freed_offsets.pop_front());
         end
      end
      pending_reqs.push_back(q);
      awaited_rsps.push_back(r);
   endtask

   task automatic queue_alloc(int unsigned size);
      queue_op(OP_ALLOC, size, $urandom_range(0, 65535));
   endtask

   task automatic queue_free(int unsigned off);
      queue_op(OP_FREE, $urandom_range(0, 65535), off);
   endtask

   task automatic queue_random_op();
      int unsigned pick, k, off;
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
         k = $urandom_range(0, 19);
         if (k == 0) queue_alloc(0);
         else if (k == 1) queue_alloc($urandom_range(0, 65535));
         else if (k == 2) queue_alloc($urandom_range(200, 4000));
         else queue_alloc($urandom_range(1, 160));
      end else if (pick < 88 && live_offsets.size() > 0) begin
         k = $urandom_range(0, live_offsets.size() - 1);
         queue_free(live_offsets[k]);
      end else if (pick < 93 && freed_offsets.size() > 0) begin
         queue_free(freed_offsets[$urandom_range(0, freed_offsets.size() - 1)]);
      end else begin
         k = $urandom_range(0, 3);
         if (k == 0) off = 0;
         else if (k == 1) off = $urandom_range(0, 65535);
         else if (k == 2) off = top_bytes + $urandom_range(0, 64);
         else off = $urandom_range(1, 400);
         queue_free(off);
      end
   endtask

   task automatic csr_write(logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_HEAP_LIMIT;
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      limit_bytes = value & 32'h1FFFF;
   endtask

   task automatic csr_check();
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_paddr <= CSR_HEAP_LIMIT;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata[LIMIT_W-1:0] !== limit_bytes[LIMIT_W-1:0]) begin
         $error("heap_limit readback: expected %0d, actual %0d", limit_bytes,
                csr_prdata[LIMIT_W-1:0]);
         err_count++;
      end
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic drain();
      while (awaited_rsps.size() > 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   function automatic int pick_gap();
      int unsigned k;
      k = $urandom_range(0, 99);
      if (k < 45) return 0;
      if (k < 92) return $urandom_range(1, 4);
      return $urandom_range(10, 60);
   endfunction

   // request driver
   always @(negedge clock) begin
      if (!reset && (!req_bus.valid || req_taken)) begin
         req_taken = 1'b0;
         if (req_gap > 0) begin
            req_gap--;
            req_bus.valid <= 1'b0;
         end else if (pending_reqs.size() > 0) begin
            req_bus.operation <= pending_reqs[0].op;
            req_bus.request_size <= pending_reqs[0].size;
            req_bus.release_offset <= pending_reqs[0].off;
            req_bus.valid <= 1'b1;
            void'(pending_reqs.pop_front());
            req_gap = pick_gap();
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // response ready, with one long hold-off per phase
   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (rsp_hold > 0) begin
         rsp_hold--;
         rsp_bus.ready <= 1'b0;
      end else if (long_hold) begin
         long_hold = 1'b0;
         rsp_hold = 400;
         rsp_bus.ready <= 1'b0;
      end else if ($urandom_range(0, 99) < 25) begin
         rsp_hold = pick_gap();
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      heap_rsp_type e;
      cycles++;
      if (req_bus.valid && req_bus.ready) req_taken = 1'b1;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (awaited_rsps.size() == 0) begin
            $error("unexpected response word: granted_offset %0d status %0d",
                   rsp_bus.granted_offset, rsp_bus.status);
            err_count++;
         end else begin
            e = awaited_rsps.pop_front();
            if (rsp_bus.granted_offset !== e.granted) begin
               $error("granted_offset: expected %0d, actual %0d", e.granted,
                      rsp_bus.granted_offset);
               err_count++;
            end
            if (rsp_bus.status !== e.status) begin
               $error("status: expected %0d, actual %0d", e.status, rsp_bus.status);
               err_count++;
            end
         end
      end
      if (cycles > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      int unsigned limits [5] = '{32'h10000, 32'd0, 32'd300, 32'h1FFFF, 32'd4096};
      int counts [5] = '{110, 30, 110, 150, 130};
      req_bus.valid = 1'b0;
      req_bus.operation = OP_ALLOC;
      req_bus.request_size = '0;
      req_bus.release_offset = '0;
      rsp_bus.ready = 1'b0;
      for (int i = 0; i < SLOTS; i++) slot_unused[i] = 1'b1;
      list_live = 1'b0;
      head_slot = 0;
      top_bytes = 0;
      limit_bytes = LIMIT_RESET;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      csr_check();
      // directed: edges of size and offset, merges, trims, double free
      queue_alloc(0);
      queue_free(0);
      queue_free(16'hFFFF);
      queue_alloc(1);
      queue_alloc(8);
      queue_alloc(9);
      queue_alloc(100);
      queue_alloc(65535);
      queue_free(33);
      queue_free(32 + 8 + 32);
      queue_free(32 + 8 + 32);
      queue_free(32);
      queue_alloc(16);
      queue_free(32 + 8 + 32 + 16 + 32 + 8 + 32);
      queue_alloc(200);
      queue_alloc(1);
      queue_free(top_bytes);
      queue_free(live_offsets[live_offsets.size() - 1]);
      queue_alloc(65535 - 64);
      while (live_offsets.size() > 0) queue_free(live_offsets[0]);
      queue_free(32);
      drain();

      for (int p = 0; p < 5; p++) begin
         csr_write(limits[p]);
         if (p == 2) csr_check();
         long_hold = 1'b1;
         for (int n = 0; n < counts[p]; n++) queue_random_op();
         drain();
      end

      if (err_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
